// ----- rtl/lmts_pkg.sv -----
`default_nettype none

package lmts_pkg;

    // Scan line geometry.
    localparam int unsigned VISIBLE_LINES = 144;
    localparam int unsigned LAST_LINE     = 153;

    // Mode lengths in clock cycles.
    localparam logic [9:0] SEARCH_CYCLES      = 10'd80;
    localparam logic [9:0] DRAW_CYCLES        = 10'd172;
    localparam logic [9:0] HBLANK_LENGTH      = 10'd204;
    localparam logic [9:0] VBLANK_LINE_CYCLES = 10'd456;

    // Derived line limits, 9 bits so that the incremented line can be compared whole.
    localparam logic [8:0] VISIBLE_LIMIT = 9'(VISIBLE_LINES);
    localparam logic [8:0] LAST_LIMIT    = 9'(LAST_LINE);

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_ON        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STAT_IRQ_ENABLE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VBLANK_IRQ_ENABLE = 2'd2;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef struct packed {
        logic display_on;
        logic stat_irq_enable;
        logic vblank_irq_enable;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [9:0] count;
        logic [7:0] line;
    } seq_state_t;

    typedef struct packed {
        logic [5:0] cycles_elapsed;
    } step_item_t;

    typedef struct packed {
        logic [1:0] lcd_mode;
        logic [7:0] line_number;
        logic       fetch_line;
        logic       render_line;
        logic       clear_line;
        logic       stat_irq;
        logic       vblank_irq;
    } report_item_t;

endpackage

`default_nettype wire

// ----- rtl/lmts_if.sv -----
`default_nettype none

// Channel carrying cycle counts into the sequencer.
interface lmts_step_if;
    logic                    valid;
    logic                    ready;
    lmts_pkg::step_item_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Channel carrying mode and line reports out of the sequencer.
interface lmts_report_if;
    logic                    valid;
    logic                    ready;
    lmts_pkg::report_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lcd_mode_timing_sequencer_core.sv -----
// Channel   Dir  Payload                                   Transfer
// step      in   cycles_elapsed[5:0]                       valid & ready
// report    out  lcd_mode, line_number, five event pulses  valid & ready
// cfg       in   cfg_index[1:0], cfg_wdata                 cfg_we
//
// One cycle count can be taken per clock while the report is not stalled.
// The step register and the report register form a two-stage pipe; the mode,
// counter and line registers update in the cycle the step moves into the report.
// Reset clears the sequencer to object search, line 0, all enables off.
// A stalled report holds the pipe: the step register takes one more transfer,
// then step ready stays low until the report transfers.
`default_nettype none

module lcd_mode_timing_sequencer_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lmts_step_if.sink                              step,
    lmts_report_if.source                          report,
    input  wire logic                              cfg_we,
    input  wire logic [lmts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic                              cfg_wdata
);

    lmts_pkg::cfg_t          cfg;
    lmts_pkg::seq_state_t    state_reg;
    lmts_pkg::seq_state_t    state_next;
    lmts_pkg::report_item_t  result;

    logic                    in_valid_reg;
    logic [5:0]              in_cycles_reg;
    logic                    out_valid_reg;
    lmts_pkg::report_item_t  out_data_reg;
    logic                    advance;
    logic                    step_xfer;

    // Configuration registers.
    lmts_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Mode and line update for the registered step.
    lmts_step u_step
    (
        .state          (state_reg),
        .cycles_elapsed (in_cycles_reg),
        .cfg            (cfg),
        .state_next     (state_next),
        .report         (result)
    );

    // Pipe control: the step moves on when the report register is free or draining.
    assign advance    = in_valid_reg && (!out_valid_reg || report.ready);
    assign step.ready = !in_valid_reg || advance;
    assign step_xfer  = step.valid && step.ready;

    // Step register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (step.ready)
        begin
            in_valid_reg <= step.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_xfer)
        begin
            in_cycles_reg <= step.data.cycles_elapsed;
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode  <= lmts_pkg::MODE_SEARCH;
            state_reg.count <= '0;
            state_reg.line  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Report register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign report.valid = out_valid_reg;
    assign report.data  = out_data_reg;

    // The counter is always left below the longest mode length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count < lmts_pkg::VBLANK_LINE_CYCLES)
        else $error("cycle counter out of range");

    // The line never passes the last line of the frame.
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, state_reg.line} <= lmts_pkg::LAST_LIMIT)
        else $error("line register past last line");

    // A fetch pulse is only reported together with the drawing mode.
    a_fetch_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.fetch_line)
            |-> (out_data_reg.lcd_mode == lmts_pkg::MODE_DRAW))
        else $error("fetch pulse outside drawing mode");

    // Render and status pulses follow drawing and land in horizontal blank.
    a_draw_end_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.render_line || out_data_reg.stat_irq))
            |-> (out_data_reg.lcd_mode == lmts_pkg::MODE_HBLANK))
        else $error("draw end pulse outside horizontal blank");

    // A vertical blank interrupt always comes with a line clear.
    a_vblank_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.vblank_irq)
            |-> (out_data_reg.clear_line && out_data_reg.lcd_mode == lmts_pkg::MODE_VBLANK))
        else $error("vblank interrupt without line clear");

    // A report held under stall keeps its contents.
    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !report.ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled report changed");

endmodule

`default_nettype wire

// ----- rtl/lmts_cfg.sv -----
`default_nettype none

module lmts_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lmts_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic                              cfg_wdata,
    output lmts_pkg::cfg_t                         cfg
);

    lmts_pkg::cfg_t cfg_reg;
    lmts_pkg::cfg_t cfg_next;

    // Decode the register index; an index beyond the list leaves all bits alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lmts_pkg::CFG_DISPLAY_ON:        cfg_next.display_on        = cfg_wdata;
                lmts_pkg::CFG_STAT_IRQ_ENABLE:   cfg_next.stat_irq_enable   = cfg_wdata;
                lmts_pkg::CFG_VBLANK_IRQ_ENABLE: cfg_next.vblank_irq_enable = cfg_wdata;
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/lmts_step.sv -----
`default_nettype none

module lmts_step
(
    input  wire lmts_pkg::seq_state_t  state,
    input  wire logic [5:0]            cycles_elapsed,
    input  wire lmts_pkg::cfg_t        cfg,
    output lmts_pkg::seq_state_t       state_next,
    output lmts_pkg::report_item_t     report
);

    logic [9:0] sum;
    logic [8:0] line_inc;
    logic       fetch;
    logic       render;
    logic       clear;
    logic       sirq;
    logic       virq;

    // Add the elapsed cycles, then close the current mode once its length is reached.
    // Surplus cycles past the threshold are dropped.
    always_comb
    begin
        sum        = state.count + {4'b0, cycles_elapsed};
        line_inc   = {1'b0, state.line} + 9'd1;
        state_next = state;
        state_next.count = sum;
        fetch  = 1'b0;
        render = 1'b0;
        clear  = 1'b0;
        sirq   = 1'b0;
        virq   = 1'b0;

        case (state.mode)
            lmts_pkg::MODE_SEARCH:
            begin
                if (sum >= lmts_pkg::SEARCH_CYCLES)
                begin
                    state_next.count = '0;
                    state_next.mode  = lmts_pkg::MODE_DRAW;
                    fetch            = 1'b1;
                end
            end
            lmts_pkg::MODE_DRAW:
            begin
                if (sum >= lmts_pkg::DRAW_CYCLES)
                begin
                    state_next.count = '0;
                    state_next.mode  = lmts_pkg::MODE_HBLANK;
                    render           = cfg.display_on;
                    sirq             = cfg.stat_irq_enable;
                end
            end
            lmts_pkg::MODE_HBLANK:
            begin
                if (sum >= lmts_pkg::HBLANK_LENGTH)
                begin
                    state_next.count = '0;
                    state_next.line  = line_inc[7:0];
                    clear            = 1'b1;
                    if (line_inc >= lmts_pkg::VISIBLE_LIMIT)
                    begin
                        state_next.mode = lmts_pkg::MODE_VBLANK;
                        virq            = cfg.vblank_irq_enable;
                    end
                    else
                    begin
                        state_next.mode = lmts_pkg::MODE_SEARCH;
                    end
                end
            end
            default:
            begin
                // Vertical blank: one line per full line period, frame wraps past the last line.
                if (sum >= lmts_pkg::VBLANK_LINE_CYCLES)
                begin
                    state_next.count = '0;
                    if (line_inc > lmts_pkg::LAST_LIMIT)
                    begin
                        state_next.mode = lmts_pkg::MODE_SEARCH;
                        state_next.line = '0;
                    end
                    else
                    begin
                        state_next.line = line_inc[7:0];
                    end
                end
            end
        endcase

        report.lcd_mode    = state_next.mode;
        report.line_number = state_next.line;
        report.fetch_line  = fetch;
        report.render_line = render;
        report.clear_line  = clear;
        report.stat_irq    = sirq;
        report.vblank_irq  = virq;
    end

endmodule

`default_nettype wire
